// ----- rtl/square_noise_sound_generator_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the sound generator
// Clocked implication checks, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef SQUARE_NOISE_SOUND_GENERATOR_UNIT_ASSERT_SVH
`define SQUARE_NOISE_SOUND_GENERATOR_UNIT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define SNDG_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sound generator check failed");

// Consequent holds in the cycle after the antecedent.
`define SNDG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sound generator check failed");

`endif

// ----- rtl/sndg_pkg.sv -----
// ---------------------------------------------------------------------------
// Sound generator package
// Shared types, constants and the volume weighting table.
// ---------------------------------------------------------------------------
`default_nettype none
package sndg_pkg;

   localparam int DIVIDEND_W = 34;
   localparam int DIVISOR_W  = 14;
   localparam int CNT_W      = $clog2(DIVIDEND_W + 1);

   localparam logic [31:0] BASE_STEP  = 32'h2895_9bec;
   localparam logic [31:0] HALF_STEP  = 32'h8000_0000;
   localparam logic [14:0] NOISE_SEED = 15'h4000;
   localparam logic [46:0] HP_COEF    = 47'h3fe7;
   localparam logic [46:0] HP_ROUND   = 47'h3fff;
   localparam logic [31:0] RECIP3     = 32'haaaa_aaab;
   localparam logic [32:0] REM2_MARK  = 33'h1_5555_5556;
   localparam logic signed [35:0] OUT_MAX = 36'sd1048575;
   localparam logic signed [35:0] OUT_MIN = -36'sd1048576;

   localparam logic [2:0] REG_TONE0 = 3'd0;
   localparam logic [2:0] REG_TONE1 = 3'd2;
   localparam logic [2:0] REG_TONE2 = 3'd4;
   localparam logic [2:0] REG_NOISE = 3'd6;
   localparam logic [1:0] RATE_TONE = 2'd3;
   localparam logic       CMD_TICK  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_STEP_START, ST_STEP_WAIT, ST_NZ_ADD, ST_NZ_SHIFT, ST_TONE_ADD,
      ST_MIX, ST_HP_MUL, ST_HP_SUM, ST_LP_MUL, ST_LP_SUM, ST_OUT
   } sndg_state_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_sts_type;

   function automatic logic [13:0] vol_weight(input logic [3:0] v);
      logic [13:0] w;
      case (v)
         4'd0:    w = 14'h26a9;
         4'd1:    w = 14'h1eb5;
         4'd2:    w = 14'h1864;
         4'd3:    w = 14'h1360;
         4'd4:    w = 14'h0f64;
         4'd5:    w = 14'h0c39;
         4'd6:    w = 14'h09b6;
         4'd7:    w = 14'h07b6;
         4'd8:    w = 14'h0620;
         4'd9:    w = 14'h04dd;
         4'd10:   w = 14'h03dd;
         4'd11:   w = 14'h0312;
         4'd12:   w = 14'h0270;
         4'd13:   w = 14'h01f0;
         4'd14:   w = 14'h018a;
         default: w = 14'h0000;
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/sndg_if.sv -----
// ---------------------------------------------------------------------------
// Sound generator channel interfaces
// Valid/ready channels for the request and response sides.
// ---------------------------------------------------------------------------
`default_nettype none
interface sndg_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] data;
   modport source (output valid, command, data, input ready);
   modport sink (input valid, command, data, output ready);
endinterface

interface sndg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [20:0] sample;
   modport source (output valid, sample, input ready);
   modport sink (input valid, sample, output ready);
endinterface
`default_nettype wire

// ----- rtl/sndg_div.sv -----
// ---------------------------------------------------------------------------
// Sound generator serial divider
// Restoring division, one quotient bit per cycle, shared by all users.
// ---------------------------------------------------------------------------
`default_nettype none
module sndg_div import sndg_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  div_req_type req,
   output div_sts_type sts
);
   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in, dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W+1:0]  diff;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         quo_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], ~diff[DIVISOR_W+1]};
         rem_in = diff[DIVISOR_W+1] ? trial[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign sts.busy     = busy_ff;
   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;
endmodule
`default_nettype wire

// ----- rtl/square_noise_sound_generator_unit.sv -----
// A tone or noise-control write runs one step division on the shared divider
// (two divisions when the noise follows tone 2); a volume write needs no division.
// A tick runs 16 noise substeps, each a phase add plus one shift state per noise shift,
// then 16 phase steps per tone channel, a 4-channel mix and 5 filter and output states.
// Throughput is one item at a time, set by the shared serial divider and sequencer.
// Synchronous reset clears control, phase and filter state and sets steps to the half step; no clearing pass.
// ---------------------------------------------------------------------------
// Square and noise sound generator
// Sequencer driving the oscillators, mixer, filters and a shared divider.
// ---------------------------------------------------------------------------
`default_nettype none
`include "square_noise_sound_generator_unit_assert.svh"
module square_noise_sound_generator_unit import sndg_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   sndg_req_if.sink   req_ch,
   sndg_rsp_if.source rsp_ch
);
   sndg_state_type      state_ff, state_in;
   logic [9:0]          tone_ff [3];
   logic [9:0]          tone_in [3];
   logic [2:0]          ctrl_ff, ctrl_in, latch_ff, latch_in;
   logic [14:0]         noise_ff, noise_in;
   logic [31:0]         phase_ff [4];
   logic [31:0]         phase_in [4];
   logic [31:0]         step_ff [4];
   logic [31:0]         step_in [4];
   logic [3:0]          vol_ff [4];
   logic [3:0]          vol_in [4];
   logic [4:0]          onv_ff [4];
   logic [4:0]          onv_in [4];
   logic signed [31:0]  hp_ff, hp_in, lp_ff, lp_in;
   logic [16:0]         prev_ff, prev_in, mix_ff, mix_in;
   logic [1:0]          ch_ff, ch_in;
   logic [3:0]          k_ff, k_in, cnt_ff, cnt_in;
   logic [4:0]          on_ff, on_in;
   logic signed [46:0]  prod_ff, prod_in;
   logic                neg_ff, neg_in, more_ff, more_in, rsp_valid_ff, rsp_valid_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic signed [20:0]  sample_ff, sample_in;
   logic [31:0]         mag_ff, mag_in;
   logic [63:0]         recip_ff, recip_in;

   div_req_type div_req;
   div_sts_type div_sts;

   logic [2:0]         wr_sel;
   logic [1:0]         wr_idx;
   logic [9:0]         wr_per;
   logic               wr_tone;
   logic [31:0]        nz_sum, t_sum;
   logic               fb;
   logic [14:0]        nz_nx;
   logic               sub_done, sub_bit;
   logic [4:0]         on_sub;
   logic [17:0]        term;
   logic signed [46:0] hp_ext, prod_rnd;
   logic [31:0]        hp_new;
   logic [32:0]        lp_diff, lp_mag;
   logic [31:0]        lp_quo;
   logic signed [35:0] lp_ext, x9;

   sndg_div u_div (.clock(clock), .reset(reset), .req(div_req), .sts(div_sts));

   assign wr_sel  = req_ch.data[7] ? req_ch.data[6:4] : latch_ff;
   assign wr_idx  = wr_sel[2:1];
   assign wr_tone = wr_sel inside {REG_TONE0, REG_TONE1, REG_TONE2};
   assign wr_per  = req_ch.data[7] ? {tone_ff[wr_idx][9:4], req_ch.data[3:0]}
                                   : {req_ch.data[5:0], tone_ff[wr_idx][3:0]};
   assign nz_sum  = phase_ff[3] + step_ff[3];
   assign t_sum   = phase_ff[ch_ff] + step_ff[ch_ff];
   assign fb      = ctrl_ff[2] ? (noise_ff[0] ^ noise_ff[1]) : noise_ff[0];
   assign nz_nx   = {fb, noise_ff[14:1]};
   assign on_sub  = on_ff + {4'b0000, sub_bit};
   assign term    = 18'(onv_ff[ch_ff]) * 18'(vol_weight(vol_ff[ch_ff]));
   assign hp_ext  = 47'(hp_ff);
   assign prod_rnd = prod_ff[46] ? prod_ff + HP_ROUND : prod_ff;
   assign hp_new  = {15'b0, mix_ff} - {15'b0, prev_ff} + prod_rnd[45:14];
   assign lp_diff = {hp_new[31], hp_new} - {lp_ff[31], lp_ff};
   assign lp_mag  = lp_diff[32] ? -lp_diff : lp_diff;
   // Twice the third of the magnitude: the low product bits give the remainder.
   assign lp_quo  = {recip_ff[63:33], 1'b0} + {31'b0, (recip_ff[32:0] >= REM2_MARK)};
   assign lp_ext  = 36'(lp_ff);
   assign x9      = (lp_ext <<< 3) + lp_ext;

   always_comb begin
      state_in = state_ff;
      tone_in  = tone_ff;
      ctrl_in  = ctrl_ff;
      latch_in = latch_ff;
      noise_in = noise_ff;
      phase_in = phase_ff;
      step_in  = step_ff;
      vol_in   = vol_ff;
      onv_in   = onv_ff;
      hp_in    = hp_ff;
      lp_in    = lp_ff;
      prev_in  = prev_ff;
      mix_in   = mix_ff;
      ch_in    = ch_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      on_in    = on_ff;
      prod_in  = prod_ff;
      neg_in   = neg_ff;
      more_in  = more_ff;
      mag_in   = mag_ff;
      recip_in = recip_ff;
      divisor_in = divisor_ff;
      sample_in  = sample_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      div_req  = '0;
      sub_done = 1'b0;
      sub_bit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.command == CMD_TICK) begin
                  k_in     = '0;
                  on_in    = '0;
                  state_in = ST_NZ_ADD;
               end else begin
                  if (req_ch.data[7]) begin
                     latch_in = wr_sel;
                  end
                  if (wr_tone) begin
                     tone_in[wr_idx] = wr_per;
                     divisor_in = {4'b0000, wr_per};
                     ch_in      = wr_idx;
                     more_in    = (wr_sel == REG_TONE2) && (ctrl_ff[1:0] == RATE_TONE);
                     state_in   = ST_STEP_START;
                  end else if (req_ch.data[7] && wr_sel == REG_NOISE) begin
                     ctrl_in  = req_ch.data[2:0];
                     noise_in = NOISE_SEED;
                     ch_in    = 2'd3;
                     more_in  = 1'b0;
                     divisor_in = (req_ch.data[1:0] == RATE_TONE) ? {tone_ff[2], 4'b0000}
                                  : (DIVISOR_W'(256) << req_ch.data[1:0]);
                     state_in = ST_STEP_START;
                  end else if (req_ch.data[7]) begin
                     vol_in[wr_idx] = req_ch.data[3:0];
                  end
               end
            end
         end
         ST_STEP_START: begin
            if (divisor_ff == '0) begin
               step_in[ch_ff] = HALF_STEP;
               if (more_ff) begin
                  more_in    = 1'b0;
                  ch_in      = 2'd3;
                  divisor_in = {tone_ff[2], 4'b0000};
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIVIDEND_W'(BASE_STEP);
               div_req.divisor  = divisor_ff;
               state_in         = ST_STEP_WAIT;
            end
         end
         ST_STEP_WAIT: begin
            if (div_sts.done) begin
               step_in[ch_ff] = div_sts.quotient[31:0];
               if (more_ff) begin
                  more_in    = 1'b0;
                  ch_in      = 2'd3;
                  divisor_in = {tone_ff[2], 4'b0000};
                  state_in   = ST_STEP_START;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_NZ_ADD: begin
            phase_in[3] = {4'b0000, nz_sum[27:0]};
            cnt_in      = nz_sum[31:28];
            if (nz_sum[31:28] == 4'd0) begin
               sub_done = 1'b1;
               sub_bit  = noise_ff[0];
            end else begin
               state_in = ST_NZ_SHIFT;
            end
         end
         ST_NZ_SHIFT: begin
            noise_in = nz_nx;
            cnt_in   = cnt_ff - 4'd1;
            if (cnt_ff == 4'd1) begin
               sub_done = 1'b1;
               sub_bit  = nz_nx[0];
            end
         end
         ST_TONE_ADD: begin
            phase_in[ch_ff] = t_sum;
            k_in = k_ff + 4'd1;
            if (k_ff == 4'd15) begin
               onv_in[ch_ff] = on_ff + {4'b0000, t_sum[31]};
               on_in = '0;
               if (ch_ff == 2'd2) begin
                  ch_in    = 2'd0;
                  mix_in   = '0;
                  state_in = ST_MIX;
               end else begin
                  ch_in = ch_ff + 2'd1;
               end
            end else begin
               on_in = on_ff + {4'b0000, t_sum[31]};
            end
         end
         ST_MIX: begin
            mix_in = mix_ff + {2'b00, term[17:4]};
            ch_in  = ch_ff + 2'd1;
            if (ch_ff == 2'd3) begin
               state_in = ST_HP_MUL;
            end
         end
         ST_HP_MUL: begin
            prod_in  = hp_ext * $signed(HP_COEF);
            state_in = ST_HP_SUM;
         end
         ST_HP_SUM: begin
            hp_in   = hp_new;
            prev_in = mix_ff;
            neg_in  = lp_diff[32];
            mag_in  = lp_mag[31:0];
            state_in = ST_LP_MUL;
         end
         ST_LP_MUL: begin
            recip_in = mag_ff * RECIP3;
            state_in = ST_LP_SUM;
         end
         ST_LP_SUM: begin
            lp_in = neg_ff ? lp_ff - lp_quo : lp_ff + lp_quo;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               if (x9 > OUT_MAX) begin
                  sample_in = OUT_MAX[20:0];
               end else if (x9 < OUT_MIN) begin
                  sample_in = OUT_MIN[20:0];
               end else begin
                  sample_in = x9[20:0];
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (sub_done) begin
         k_in = k_ff + 4'd1;
         if (k_ff == 4'd15) begin
            onv_in[3] = on_sub;
            on_in     = '0;
            ch_in     = 2'd0;
            state_in  = ST_TONE_ADD;
         end else begin
            on_in    = on_sub;
            state_in = ST_NZ_ADD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tone_ff      <= '{default: '0};
         ctrl_ff      <= '0;
         latch_ff     <= '0;
         noise_ff     <= '0;
         phase_ff     <= '{default: '0};
         step_ff      <= '{default: HALF_STEP};
         vol_ff       <= '{default: '0};
         hp_ff        <= '0;
         lp_ff        <= '0;
         prev_ff      <= '0;
         more_ff      <= 1'b0;
         ch_ff        <= '0;
         k_ff         <= '0;
         cnt_ff       <= '0;
         on_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tone_ff      <= tone_in;
         ctrl_ff      <= ctrl_in;
         latch_ff     <= latch_in;
         noise_ff     <= noise_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         vol_ff       <= vol_in;
         hp_ff        <= hp_in;
         lp_ff        <= lp_in;
         prev_ff      <= prev_in;
         more_ff      <= more_in;
         ch_ff        <= ch_in;
         k_ff         <= k_in;
         cnt_ff       <= cnt_in;
         on_ff        <= on_in;
      end
      onv_ff     <= onv_in;
      mix_ff     <= mix_in;
      prod_ff    <= prod_in;
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      recip_ff   <= recip_in;
      divisor_ff <= divisor_in;
      sample_ff  <= sample_in;
   end

   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.sample = sample_ff;

   // The divider is never restarted while a division is still running.
   `SNDG_ASSERT_SAME(a_div_start_idle, div_req.start, !div_sts.busy)
   // A new response only appears after the output stage has run.
   `SNDG_ASSERT_SAME(a_rsp_from_out, $rose(rsp_valid_ff), $past(state_ff == ST_OUT))
   // The noise phase never keeps whole-step bits between ticks.
   `SNDG_ASSERT_SAME(a_noise_phase, state_ff == ST_IDLE, phase_ff[3][31:28] == 4'd0)
   // A finished division is always consumed by the waiting state.
   `SNDG_ASSERT_SAME(a_div_done_used, div_sts.done, state_ff == ST_STEP_WAIT)
endmodule
`default_nettype wire
